@@ sv/kbht_pkg.sv @@
// Shared types, codes and handshake structs of the keyed bucket hash table.
package kbht_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 14;
  localparam int IO_REC_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PRESENT   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SCALE,
    S_REDUCE,
    S_ROW,
    S_DECIDE,
    S_ACT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic hash;
    logic scale;
    logic reduce;
    logic row;
    logic decide;
    logic act;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dstat_t;

endpackage

@@ sv/kbht_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module kbht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/kbht_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
module kbht_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  kbht_pkg::dstat_t dstat,
  output kbht_pkg::cmd_t  cmd,
  output logic            in_stall
);
  import kbht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (dstat.clear_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_HASH;
      S_HASH:   state_next = S_SCALE;
      S_SCALE:  state_next = S_REDUCE;
      S_REDUCE: state_next = S_ROW;
      S_ROW:    state_next = S_DECIDE;
      S_DECIDE: state_next = S_ACT;
      S_ACT:    state_next = S_RESP;
      S_RESP:   if (dstat.out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE:   cmd.capture = in_valid;
      S_HASH:   cmd.hash = 1'b1;
      S_SCALE:  cmd.scale = 1'b1;
      S_REDUCE: cmd.reduce = 1'b1;
      S_ROW:    cmd.row = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_ACT:    cmd.act = 1'b1;
      S_RESP:   cmd.resp = dstat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ sv/kbht_dpath.sv @@
// Datapath: bucket hashing, bucket row memories, way compare and result register.
module kbht_dpath #(
  parameter int BUCKETS     = 128,
  parameter int WAYS        = 4,
  parameter int RECORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kbht_pkg::cmd_t                 cmd,
  output kbht_pkg::dstat_t               dstat,
  input  logic [kbht_pkg::KIND_W-1:0]    kind,
  input  logic [kbht_pkg::KEY_W-1:0]     customer_id,
  input  logic [kbht_pkg::IO_REC_W-1:0]  record_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kbht_pkg::STATUS_W-1:0]  status,
  output logic [kbht_pkg::IO_REC_W-1:0]  record_out
);
  import kbht_pkg::*;

  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HSH     = 28;
  localparam int RECIP_W = HSH + 1;
  localparam int PROD_W  = RECIP_W + KEY_W;
  localparam int BVW     = $clog2(BUCKETS + 1);
  localparam int QB_W    = KEY_W + BVW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << HSH) / BUCKETS);

  // Captured request.
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [IO_REC_W-1:0] rec_q;

  // Bucket computation: quotient by reciprocal, then one correction step.
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  quot;
  logic [QB_W-1:0]   qb_prod;
  logic [QB_W-1:0]   diff;
  logic [QB_W-1:0]   rem;
  logic [BW-1:0]     bucket;
  logic [SW-1:0]     base;
  logic [BW-1:0]     clr_cnt;

  // Row memories and their read data.
  logic [WAYS-1:0]             vrow_rd;
  logic [WAYS-1:0][KEY_W-1:0]  krow_rd;
  logic [WAYS-1:0]             vrow_new;
  logic [WAYS-1:0][KEY_W-1:0]  krow_new;
  logic [RECORD_BITS-1:0]      rec_rd;
  logic                        v_we;
  logic                        k_we;
  logic                        r_we;
  logic [BW-1:0]               v_waddr;
  logic [WAYS-1:0]             v_wdata;

  // Way compare.
  logic [WAYS-1:0] hit_vec;
  logic            found;
  logic [WW-1:0]   found_way;
  logic            has_free;
  logic [WW-1:0]   first_free;
  logic            hit;
  logic [WW-1:0]   hit_way;
  logic            free_ok;
  logic [WW-1:0]   free_way;
  logic [SW-1:0]   slot;

  // Result of the action step.
  logic [STATUS_W-1:0] act_status;
  logic                act_lookup;
  logic [STATUS_W-1:0] res_status;
  logic                res_lookup;
  logic [63:0]         rec_wide;

  assign prod = PROD_W'(key_q) * PROD_W'(RECIP);
  assign diff = QB_W'(key_q) - qb_prod;
  assign rem  = (diff >= QB_W'(BUCKETS)) ? (diff - QB_W'(BUCKETS)) : diff;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      key_q  <= customer_id;
      rec_q  <= record_in;
    end
    if (cmd.hash) begin
      quot <= prod[HSH +: KEY_W];
    end
    if (cmd.scale) begin
      qb_prod <= QB_W'(quot) * QB_W'(BUCKETS);
    end
    if (cmd.reduce) begin
      bucket <= BW'(rem);
    end
    if (cmd.row) begin
      base <= SW'(32'(bucket) * WAYS);
    end
    if (cmd.decide) begin
      hit      <= found;
      hit_way  <= found_way;
      free_ok  <= has_free;
      free_way <= first_free;
    end
    if (cmd.act) begin
      res_status <= act_status;
      res_lookup <= act_lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + BW'(1);
    end
  end

  assign dstat.clear_last = (clr_cnt == BW'(BUCKETS - 1));

  always_comb begin
    found      = 1'b0;
    found_way  = '0;
    has_free   = 1'b0;
    first_free = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vrow_rd[w] && (krow_rd[w] == key_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        found     = 1'b1;
        found_way = WW'(w);
      end
      if (!vrow_rd[w]) begin
        has_free   = 1'b1;
        first_free = WW'(w);
      end
    end
  end

  // The hit way serves lookups and removes; a new entry goes to the free way.
  assign slot = base + SW'(hit ? hit_way : free_way);

  always_comb begin
    vrow_new   = vrow_rd;
    krow_new   = krow_rd;
    v_we       = 1'b0;
    k_we       = 1'b0;
    r_we       = 1'b0;
    act_status = STAT_NOT_FOUND;
    act_lookup = 1'b0;
    unique case (kind_q)
      KIND_LOOKUP: begin
        if (hit) begin
          act_status = STAT_OK;
          act_lookup = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (hit) begin
          act_status = STAT_PRESENT;
        end else if (!free_ok) begin
          act_status = STAT_FULL;
        end else begin
          vrow_new[free_way] = 1'b1;
          krow_new[free_way] = key_q;
          v_we       = cmd.act;
          k_we       = cmd.act;
          r_we       = cmd.act;
          act_status = STAT_OK;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          vrow_new[hit_way] = 1'b0;
          v_we       = cmd.act;
          act_status = STAT_OK;
        end
      end
      default: act_status = STAT_NOT_FOUND;
    endcase
  end

  assign v_waddr = cmd.clear ? clr_cnt : bucket;
  assign v_wdata = cmd.clear ? '0 : vrow_new;

  kbht_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
    .clk   (clk),
    .we    (cmd.clear || v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (bucket),
    .rdata (vrow_rd)
  );

  kbht_ram #(.WIDTH(WAYS * KEY_W), .DEPTH(BUCKETS)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (bucket),
    .wdata (krow_new),
    .raddr (bucket),
    .rdata (krow_rd)
  );

  kbht_ram #(.WIDTH(RECORD_BITS), .DEPTH(SLOTS)) u_record_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (slot),
    .wdata (RECORD_BITS'(rec_q)),
    .raddr (slot),
    .rdata (rec_rd)
  );

  assign rec_wide = 64'(rec_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      status     <= res_status;
      record_out <= res_lookup ? rec_wide[IO_REC_W-1:0] : '0;
    end
  end

  assign dstat.out_free = !out_valid || !out_stall;

endmodule

@@ sv/keyed_bucket_hash_table_unit.sv @@
// Top level of the keyed bucket hash table: controller plus datapath.
//
// Each input item is a request (lookup, insert or remove) keyed by
// customer_id; each request yields exactly one result item carrying a
// status and, for a successful lookup, the stored record.
// Both channels use valid and stall. An item moves at a rising edge where
// valid is high and stall is low.
// The bucket is customer_id modulo BUCKETS, found by multiplying with a
// constant reciprocal and correcting once. Each bucket holds WAYS entries;
// the valid bits and keys of a whole bucket live in one memory row each,
// so all ways are compared in parallel, and records sit in a slot memory.
// The block works on one request at a time. A request passes through the
// hash, scale and reduce steps, the registered row reads, the way decision,
// the action with its record memory read and the response step; the next
// request is taken only after the result item has been registered.
// After reset the block runs a clearing pass over the valid-bit memory,
// one bucket row a cycle over all BUCKETS rows, holding in_stall high.
// When the receiver stalls, the result item holds in the output register;
// a further request is still accepted and waits in its final step until
// the output register is free.
module keyed_bucket_hash_table_unit #(
  parameter int BUCKETS     = 128,
  parameter int WAYS        = 4,
  parameter int RECORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kbht_pkg::KIND_W-1:0]    kind,
  input  logic [kbht_pkg::KEY_W-1:0]     customer_id,
  input  logic [kbht_pkg::IO_REC_W-1:0]  record_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kbht_pkg::STATUS_W-1:0]  status,
  output logic [kbht_pkg::IO_REC_W-1:0]  record_out
);
  import kbht_pkg::*;

  // Commands from the controller and status back from the datapath.
  cmd_t   cmd;
  dstat_t dstat;

  kbht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .dstat    (dstat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  kbht_dpath #(
    .BUCKETS     (BUCKETS),
    .WAYS        (WAYS),
    .RECORD_BITS (RECORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dstat       (dstat),
    .kind        (kind),
    .customer_id (customer_id),
    .record_in   (record_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .record_out  (record_out)
  );

endmodule

@@ sv/kbht_checker.sv @@
// Port-level checker for the keyed bucket hash table, bound to the top level.
module kbht_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [kbht_pkg::KIND_W-1:0]    kind,
  input logic [kbht_pkg::KEY_W-1:0]     customer_id,
  input logic [kbht_pkg::IO_REC_W-1:0]  record_in,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kbht_pkg::STATUS_W-1:0]  status,
  input logic [kbht_pkg::IO_REC_W-1:0]  record_out
);
  import kbht_pkg::*;

  // Reset starts the clearing pass: no requests taken, no result shown.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

  // A stalled result holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(record_out))
    else $error("stalled result changed");

  // Only a successful lookup returns a nonzero record.
  a_record_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_out != '0) |-> status == STAT_OK)
    else $error("record returned with failing status");

  // One request at a time: an accepted request closes the input.
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in progress");

  // A result never shows up right after an accept.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind keyed_bucket_hash_table_unit kbht_checker u_kbht_checker (.*);
